FILE: hdl/ordered_timer_queue_core_assert.svh
// Assertion macros for the timer queue core.
`ifndef ORDERED_TIMER_QUEUE_CORE_ASSERT_SVH
`define ORDERED_TIMER_QUEUE_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define OTQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define OTQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/otq_pkg.sv
package otq_pkg;

  localparam int unsigned SeqBits = 16;
  localparam int unsigned KindBits = 3;
  localparam int unsigned MaxOut = 16;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [KindBits-1:0] {
    EV_ADDED     = 3'd0,
    EV_CANCELLED = 3'd1,
    EV_MISSED    = 3'd2,
    EV_EXPIRED   = 3'd3,
    EV_NONE      = 3'd4,
    EV_FULL      = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT,
    ST_FINAL,
    ST_OUT
  } state_e;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic scan;      // shift the scan token one cell down the row
    logic clr_live;  // clear live of the cell named by sel
    logic set_live;  // set live of the cell named by sel
    logic wr_exp;    // write expiry of the cell named by sel
    logic wr_all;    // write expiry, interval and sequence of the cell named by sel
  } cell_cmd_t;

endpackage

FILE: hdl/otq_cell.sv
// One timer slot. During a scan the cell compares its entry against the
// running minimum coming from its lower neighbor and passes the winner on.
module otq_cell #(
  parameter int unsigned TimeBits = 48,
  parameter int unsigned SlotBits = 4,
  parameter int unsigned MyIndex  = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  otq_pkg::cell_cmd_t     cmd_i,
  input  logic [SlotBits-1:0]    sel_i,
  input  logic [TimeBits-1:0]    wr_exp_i,
  input  logic [TimeBits-1:0]    wr_iv_i,
  input  logic [otq_pkg::SeqBits-1:0] wr_seq_i,
  input  logic [TimeBits-1:0]    now_i,
  input  logic                   due_only_i,
  input  logic                   excl_i,
  // running minimum from the neighbor
  input  logic                   min_vld_i,
  input  logic [TimeBits-1:0]    min_exp_i,
  input  logic [SlotBits-1:0]    min_slot_i,
  output logic                   min_vld_o,
  output logic [TimeBits-1:0]    min_exp_o,
  output logic [SlotBits-1:0]    min_slot_o,
  output logic                   live_o,
  output logic [TimeBits-1:0]    iv_o,
  output logic [otq_pkg::SeqBits-1:0] seq_o
);
  import otq_pkg::*;

  localparam logic [SlotBits-1:0] Me = SlotBits'(MyIndex);

  logic                live_q;
  logic [TimeBits-1:0] exp_q, iv_q;
  logic [SeqBits-1:0]  seq_q;
  logic                mine, cand;

  assign mine = (sel_i == Me);
  // excl_i keeps this slot out: taken in the current tick, or not at the scan token
  assign cand = live_q && !excl_i && (!due_only_i || exp_q <= now_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (mine && cmd_i.set_live) begin
      live_q <= 1'b1;
    end else if (mine && cmd_i.clr_live) begin
      live_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mine && (cmd_i.wr_exp || cmd_i.wr_all)) begin
      exp_q <= wr_exp_i;
    end
    if (mine && cmd_i.wr_all) begin
      iv_q  <= wr_iv_i;
      seq_q <= wr_seq_i;
    end
  end

  // strict less keeps the lower slot on ties, as the scan runs upward
  always_comb begin
    if (cand && (!min_vld_i || exp_q < min_exp_i)) begin
      min_vld_o  = 1'b1;
      min_exp_o  = exp_q;
      min_slot_o = Me;
    end else begin
      min_vld_o  = min_vld_i;
      min_exp_o  = min_exp_i;
      min_slot_o = min_slot_i;
    end
  end

  assign live_o = live_q;
  assign iv_o   = iv_q;
  assign seq_o  = seq_q;

endmodule

FILE: hdl/otq_row.sv
// Row of cells. The running minimum moves one cell per cycle while scan is
// commanded, held in a single minimum register shared by all cells.
module otq_row #(
  parameter int unsigned TimerSlots = 16,
  parameter int unsigned TimeBits   = 48,
  parameter int unsigned SlotBits   = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  otq_pkg::cell_cmd_t         cmd_i,
  input  logic [SlotBits-1:0]        sel_i,
  input  logic [TimeBits-1:0]        wr_exp_i,
  input  logic [TimeBits-1:0]        wr_iv_i,
  input  logic [otq_pkg::SeqBits-1:0] wr_seq_i,
  input  logic [TimeBits-1:0]        now_i,
  input  logic                       due_only_i,
  input  logic [TimerSlots-1:0]      excl_i,
  input  logic                       scan_start_i,
  output logic                       min_vld_o,
  output logic [TimeBits-1:0]        min_exp_o,
  output logic [SlotBits-1:0]        min_slot_o,
  output logic [TimerSlots-1:0]      live_o,
  output logic [TimeBits-1:0]        iv_o,
  output logic [otq_pkg::SeqBits-1:0] seq_o
);
  import otq_pkg::*;

  logic                vld_q;
  logic [TimeBits-1:0] exp_q;
  logic [SlotBits-1:0] slot_q;
  logic [SlotBits-1:0] pos_q;
  logic [TimerSlots-1:0] c_vld;
  logic [TimeBits-1:0] c_exp  [TimerSlots];
  logic [SlotBits-1:0] c_slot [TimerSlots];
  logic [TimeBits-1:0] e_iv   [TimerSlots];
  logic [SeqBits-1:0]  e_seq  [TimerSlots];

  for (genvar g = 0; g < TimerSlots; g++) begin : g_cell
    logic            act;
    logic            pv;
    assign act = (pos_q == SlotBits'(g)) && cmd_i.scan;
    assign pv  = (g == 0) ? 1'b0 : vld_q;
    otq_cell #(.TimeBits(TimeBits), .SlotBits(SlotBits), .MyIndex(g)) u_cell (
      .clk_i, .rst_ni, .cmd_i, .sel_i, .wr_exp_i, .wr_iv_i, .wr_seq_i, .now_i,
      .due_only_i,
      .excl_i    (excl_i[g] | !act),
      .min_vld_i (pv),
      .min_exp_i (exp_q),
      .min_slot_i(slot_q),
      .min_vld_o (c_vld[g]),
      .min_exp_o (c_exp[g]),
      .min_slot_o(c_slot[g]),
      .live_o    (live_o[g]),
      .iv_o      (e_iv[g]),
      .seq_o     (e_seq[g])
    );
  end

  // the token walks the row; only the cell at the token position is active
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vld_q <= 1'b0;
    end else if (scan_start_i) begin
      pos_q <= '0;
      vld_q <= 1'b0;
    end else if (cmd_i.scan) begin
      pos_q <= pos_q + 1'b1;
      vld_q <= c_vld[pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      exp_q  <= c_exp[pos_q];
      slot_q <= c_slot[pos_q];
    end
  end

  assign min_vld_o  = vld_q;
  assign min_exp_o  = exp_q;
  assign min_slot_o = slot_q;
  assign iv_o       = e_iv[sel_i];
  assign seq_o      = e_seq[sel_i];

endmodule

FILE: hdl/ordered_timer_queue_core.sv
// An add or a tick scans the cell row, acts on its minimum and scans again for
// the final minimum; a cancel or an unused code acts first, then scans once. A
// tick rescans after each timer it expires, then gives its items one a cycle
// while the output is not stalled. One request at a time: the next is accepted
// once the last item of the previous one is loaded; each row scan sets the pace.
// Reset clears all live bits, the sequence counter and the output valid.
module ordered_timer_queue_core #(
  parameter int unsigned TIMER_SLOTS = 16,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] req_type
  input  logic [1:0]   s_axis_tuser,
  // [TB-1:0] expire_time, [2TB-1:TB] repeat_interval, [2TB+3:2TB] slot_index,
  // [2TB+19:2TB+4] slot_sequence, [3TB+19:2TB+20] now_time, zero fill to bytes
  input  logic [((3*TIME_BITS+20+7)/8)*8-1:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] event_kind
  output logic [otq_pkg::KindBits-1:0] m_axis_tuser,
  // [3:0] event_slot, [19:4] event_sequence, [20] was_rearmed,
  // [21] earliest_changed, [TB+21:22] next_expiry, [TB+22] next_valid,
  // zero fill to bytes
  output logic [((TIME_BITS+23+7)/8)*8-1:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  import otq_pkg::*;

  localparam int unsigned SlotBits = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned OutW     = ((TIME_BITS+23+7)/8)*8;
  localparam int unsigned CntBits  = $clog2(MaxOut+1);
  localparam int unsigned ListBits = $clog2(MaxOut);
  localparam logic [TIME_BITS-1:0] TMax = '1;

  // unpack
  req_e                 in_req;
  logic [TIME_BITS-1:0] in_exp, in_iv, in_now;
  logic [3:0]           in_idx;
  logic [SeqBits-1:0]   in_seq;

  state_e               state_q, state_d;
  req_e                 req_q;
  logic [TIME_BITS-1:0] exp_q, iv_q, now_q;
  logic [3:0]           idx_q;
  logic [SeqBits-1:0]   wseq_q, seq_ctr_q, seq_ctr_d, seq_nxt;
  logic [SlotBits:0]    cnt_q, cnt_d;
  logic [CntBits-1:0]   nexp_q, nexp_d, ecnt_q, ecnt_d;
  logic [TIMER_SLOTS-1:0] excl_q, excl_d, row_excl;
  logic                 final_q, final_d;  // scanning for the final minimum
  logic [SlotBits-1:0]  take_q [MaxOut];    // expired slots in order
  logic                 take_we;

  // single result of add, cancel, unused code or empty tick
  event_e               rk_q, rk_d;
  logic [3:0]           rs_q, rs_d;
  logic [SeqBits-1:0]   rq_q, rq_d;
  logic                 rc_q, rc_d;

  // output register
  logic                 ov_q;
  event_e               ok_q, ok_d;
  logic [3:0]           os_q, os_d;
  logic [SeqBits-1:0]   oq_q, oq_d;
  logic                 or_q, or_d, oc_q, oc_d, ol_q, ol_d;
  logic [TIME_BITS-1:0] onx_q;
  logic                 onv_q;

  cell_cmd_t            cmd;
  logic [SlotBits-1:0]  sel;
  logic [TIME_BITS-1:0] wr_exp;
  logic                 scan_start, due_only;
  logic                 min_vld;
  logic [TIME_BITS-1:0] min_exp;
  logic [SlotBits-1:0]  min_slot;
  logic [TIMER_SLOTS-1:0] live;
  logic [TIME_BITS-1:0] row_iv;
  logic [SeqBits-1:0]   row_seq;
  logic                 free_any;
  logic [SlotBits-1:0]  free_slot;
  logic [TIME_BITS:0]   rearm_sum;
  logic                 idx_ok;
  logic                 out_fire, load_out;
  logic                 out_stall;
  logic [OutW+KindBits:0] out_word;

  assign in_req = req_e'(s_axis_tuser);
  assign in_exp = s_axis_tdata[TIME_BITS-1:0];
  assign in_iv  = s_axis_tdata[2*TIME_BITS-1:TIME_BITS];
  assign in_idx = s_axis_tdata[2*TIME_BITS+3:2*TIME_BITS];
  assign in_seq = s_axis_tdata[2*TIME_BITS+19:2*TIME_BITS+4];
  assign in_now = s_axis_tdata[3*TIME_BITS+19:2*TIME_BITS+20];

  assign seq_nxt  = seq_ctr_q + 1'b1;
  // re-armed timers count again once the final scan runs
  assign row_excl = final_q ? '0 : excl_q;

  otq_row #(.TimerSlots(TIMER_SLOTS), .TimeBits(TIME_BITS), .SlotBits(SlotBits)) u_row (
    .clk_i, .rst_ni, .cmd_i(cmd), .sel_i(sel), .wr_exp_i(wr_exp), .wr_iv_i(iv_q),
    .wr_seq_i(seq_nxt), .now_i(now_q), .due_only_i(due_only),
    .excl_i(row_excl), .scan_start_i(scan_start),
    .min_vld_o(min_vld), .min_exp_o(min_exp), .min_slot_o(min_slot),
    .live_o(live), .iv_o(row_iv), .seq_o(row_seq)
  );

  // lowest free slot: priority encode over the live bits
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_any  = 1'b1;
        free_slot = SlotBits'(i);
      end
    end
  end

  assign rearm_sum = {1'b0, now_q} + {1'b0, row_iv};
  assign idx_ok    = ({{(32-4){1'b0}}, idx_q} < 32'(TIMER_SLOTS));
  assign out_fire  = m_axis_tvalid && m_axis_tready;
  assign due_only  = (req_q == REQ_TICK) && !final_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    nexp_d    = nexp_q;
    ecnt_d    = ecnt_q;
    excl_d    = excl_q;
    final_d   = final_q;
    seq_ctr_d = seq_ctr_q;
    rk_d = rk_q; rs_d = rs_q; rq_d = rq_q; rc_d = rc_q;
    ok_d = ok_q; os_d = os_q; oq_d = oq_q; or_d = or_q; oc_d = oc_q; ol_d = ol_q;
    cmd        = '0;
    sel        = '0;
    wr_exp     = exp_q;
    scan_start = 1'b0;
    take_we    = 1'b0;
    load_out   = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cnt_d   = '0;
          nexp_d  = '0;
          ecnt_d  = '0;
          excl_d  = '0;
          final_d = 1'b0;
          rk_d = EV_NONE; rs_d = '0; rq_d = '0; rc_d = 1'b0;
          if (in_req inside {REQ_ADD, REQ_TICK}) begin
            scan_start = 1'b1;
            state_d    = ST_SCAN;
          end else begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == (SlotBits+1)'(TIMER_SLOTS - 1)) begin
          state_d = final_q ? ST_EMIT : ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // act on the scan result, then rescan
        scan_start = 1'b1;
        cnt_d      = '0;
        final_d    = 1'b1;
        state_d    = ST_SCAN;
        case (req_q)
          REQ_ADD: begin
            if (free_any) begin
              sel          = free_slot;
              cmd.wr_all   = 1'b1;
              cmd.set_live = 1'b1;
              seq_ctr_d    = seq_nxt;
              rk_d = EV_ADDED; rs_d = 4'(free_slot); rq_d = seq_nxt;
              rc_d = !min_vld || (exp_q < min_exp);
            end else begin
              rk_d = EV_FULL;
            end
          end
          REQ_CANCEL: begin
            sel  = SlotBits'(idx_q);
            rs_d = idx_q;
            rq_d = wseq_q;
            if (idx_ok && live[SlotBits'(idx_q)] && row_seq == wseq_q) begin
              cmd.clr_live = 1'b1;
              rk_d = EV_CANCELLED;
            end else begin
              rk_d = EV_MISSED;
            end
          end
          REQ_TICK: begin
            if (min_vld && nexp_q != CntBits'(MaxOut)) begin
              sel = min_slot;
              if (row_iv != '0) begin
                cmd.wr_exp = 1'b1;
                wr_exp = (rearm_sum[TIME_BITS]) ? TMax : rearm_sum[TIME_BITS-1:0];
              end else begin
                cmd.clr_live = 1'b1;
              end
              excl_d[min_slot] = 1'b1;
              take_we = 1'b1;
              nexp_d  = nexp_q + 1'b1;
              final_d = 1'b0;
            end
          end
          default: ;
        endcase
      end
      ST_EMIT: begin
        if (!ov_q || out_fire) begin
          load_out = 1'b1;
          ol_d     = 1'b1;
          if (req_q == REQ_TICK && nexp_q != '0) begin
            sel  = take_q[ecnt_q[ListBits-1:0]];
            ok_d = EV_EXPIRED; os_d = 4'(sel); oq_d = row_seq;
            or_d = (row_iv != '0); oc_d = 1'b0;
            ol_d = (ecnt_q + 1'b1 == nexp_q);
            ecnt_d = ecnt_q + 1'b1;
          end else begin
            ok_d = rk_q; os_d = rs_q; oq_d = rq_q; or_d = 1'b0; oc_d = rc_q;
          end
          if (ol_d) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      seq_ctr_q <= '0;
      cnt_q     <= '0;
      nexp_q    <= '0;
      ecnt_q    <= '0;
      excl_q    <= '0;
      final_q   <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      seq_ctr_q <= seq_ctr_d;
      cnt_q     <= cnt_d;
      nexp_q    <= nexp_d;
      ecnt_q    <= ecnt_d;
      excl_q    <= excl_d;
      final_q   <= final_d;
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (out_fire) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q  <= in_req;
      exp_q  <= in_exp;
      iv_q   <= in_iv;
      now_q  <= in_now;
      idx_q  <= in_idx;
      wseq_q <= in_seq;
    end
    if (take_we) begin
      take_q[nexp_q[ListBits-1:0]] <= min_slot;
    end
    rk_q <= rk_d; rs_q <= rs_d; rq_q <= rq_d; rc_q <= rc_d;
    ok_q <= ok_d; os_q <= os_d; oq_q <= oq_d; or_q <= or_d; oc_q <= oc_d; ol_q <= ol_d;
    // the row holds the final minimum while items go out
    if (load_out) begin
      onx_q <= min_vld ? min_exp : '0;
      onv_q <= min_vld;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = ok_q;
  assign m_axis_tlast  = ol_q;
  assign m_axis_tdata  = OutW'({onv_q, onx_q, oc_q, or_q, oq_q, os_q});

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  `include "ordered_timer_queue_core_assert.svh"
  `OTQ_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != ST_IDLE, !s_axis_tready, "busy")
  `OTQ_ASSERT_NEXT(a_out_valid, clk_i, rst_ni, out_stall, m_axis_tvalid, "item dropped")
  `OTQ_ASSERT_NEXT(a_out_data, clk_i, rst_ni, out_stall, $stable(out_word), "item changed")
  `OTQ_ASSERT_IMP(a_exp_bound, clk_i, rst_ni, 1'b1, nexp_q <= CntBits'(MaxOut), "too many")

endmodule
